// File: rtl/sha_pkg.sv
// SHA-256 hasher package: shared types, constants and a rotate function.
// No dependencies.
package sha_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } item_type;

   localparam logic [31:0] H_INIT [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [31:0] K_TAB [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: rtl/sha_front.sv
// Input stage: registers accepted transactions and offers them to the core.
// Depends on sha_pkg.
module sha_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sha_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output sha_pkg::item_type out_item
);
   import sha_pkg::*;

   localparam int DEPTH = 2;

   item_type      buf_ff [0:DEPTH-1];
   logic          wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          push, pop;

   assign in_ready  = (cnt_ff != 2'(DEPTH));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = buf_ff[rd_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wr_ff] <= in_item;
      end
   end

endmodule

// File: rtl/sha_core.sv
// Back end: block assembly, padding, 64 compression rounds and digest output.
// Depends on sha_pkg.
module sha_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sha_pkg::item_type in_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_digest_word,
   output logic [2:0]        rsp_word_number,
   output logic              rsp_last_word
);
   import sha_pkg::*;

   state_type     state_ff, state_in;
   logic [6:0]    fill_ff, fill_in;
   logic [63:0]   len_ff, len_in;
   logic [31:0]   h_ff [0:7];
   logic [31:0]   v_ff [0:7];
   logic [31:0]   w_ff [0:15];
   logic [5:0]    rnd_ff, rnd_in;
   logic          fin_ff, fin_in;
   logic          more_ff, more_in;
   logic          pad_ff, pad_in;
   logic [2:0]    wn_ff, wn_in;

   logic          take, start, load_blk, do_pad, pad_second, do_add;
   logic [5:0]    pos;
   logic [31:0]   w_new, wt, t1, t2, s0, s1, ch, mj, g0, g1;

   assign take     = in_valid & in_ready;
   assign in_ready = (state_ff == ST_IDLE);
   assign pos      = fill_ff[5:0];

   always_comb begin
      g0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      g1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + g0 + w_ff[9] + g1;
      wt = w_ff[0];
      s1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + s1 + ch + K_TAB[rnd_ff] + wt;
      s0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = s0 + mj;
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      len_in     = len_ff;
      rnd_in     = rnd_ff;
      fin_in     = fin_ff;
      more_in    = more_ff;
      pad_in     = pad_ff;
      wn_in      = wn_ff;
      start      = 1'b0;
      do_pad     = 1'b0;
      pad_second = 1'b0;
      do_add     = 1'b0;
      load_blk   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               load_blk = in_item.byte_present;
               fin_in   = in_item.end_of_message;
               if (in_item.byte_present) begin
                  len_in  = len_ff + 64'd8;
                  fill_in = fill_ff + 7'd1;
               end
               if (in_item.byte_present && fill_ff == 7'd63) begin
                  fill_in  = 7'd0;
                  start    = 1'b1;
                  state_in = ST_ROUND;
               end else if (in_item.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            do_pad = 1'b1;
            start  = 1'b1;
            pad_in = 1'b1;
            more_in = (pos >= 6'd56);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            do_add = 1'b1;
            if (more_ff) begin
               more_in    = 1'b0;
               pad_second = 1'b1;
               start      = 1'b1;
               state_in   = ST_ROUND;
            end else if (fin_ff && pad_ff) begin
               wn_in    = 3'd0;
               state_in = ST_EMIT;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               wn_in = wn_ff + 3'd1;
               if (wn_ff == 3'd7) begin
                  fin_in   = 1'b0;
                  pad_in   = 1'b0;
                  fill_in  = 7'd0;
                  len_in   = 64'd0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_word = h_ff[wn_ff];
   assign rsp_word_number = wn_ff;
   assign rsp_last_word   = (wn_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= 7'd0;
         len_ff   <= 64'd0;
         rnd_ff   <= 6'd0;
         fin_ff   <= 1'b0;
         more_ff  <= 1'b0;
         pad_ff   <= 1'b0;
         wn_ff    <= 3'd0;
         for (int k = 0; k < 8; k++) begin
            h_ff[k] <= H_INIT[k];
         end
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         rnd_ff   <= start ? 6'd0 : rnd_in;
         fin_ff   <= fin_in;
         more_ff  <= more_in;
         pad_ff   <= pad_in;
         wn_ff    <= wn_in;
         if (do_add) begin
            for (int k = 0; k < 8; k++) begin
               h_ff[k] <= h_ff[k] + v_ff[k];
            end
         end else if (state_ff == ST_EMIT && rsp_ready && wn_ff == 3'd7) begin
            for (int k = 0; k < 8; k++) begin
               h_ff[k] <= H_INIT[k];
            end
         end
      end
   end

   // The schedule window holds the incoming block bytes while the core is idle.
   always_ff @(posedge clock) begin
      if (state_ff == ST_ROUND) begin
         for (int t = 0; t < 15; t++) begin
            w_ff[t] <= w_ff[t+1];
         end
         w_ff[15] <= w_new;
      end else if (pad_second) begin
         for (int t = 0; t < 16; t++) begin
            w_ff[t] <= (t >= 14) ? len_ff[(15-t)*32 +: 32] : 32'd0;
         end
      end else if (do_pad) begin
         for (int t = 0; t < 16; t++) begin
            for (int b = 0; b < 4; b++) begin
               if (6'(4*t+b) == pos) begin
                  w_ff[t][31-8*b -: 8] <= PAD_BYTE;
               end else if (6'(4*t+b) > pos) begin
                  w_ff[t][31-8*b -: 8] <= (pos < 6'd56 && t >= 14) ?
                     len_ff[(63-4*t-b)*8 +: 8] : 8'd0;
               end
            end
         end
      end else if (load_blk) begin
         for (int b = 0; b < 4; b++) begin
            if (pos[1:0] == 2'(b)) begin
               w_ff[pos[5:2]][31-8*b -: 8] <= in_item.data_byte;
            end
         end
      end
      if (start) begin
         for (int k = 0; k < 8; k++) begin
            v_ff[k] <= do_add ? h_ff[k] + v_ff[k] : h_ff[k];
         end
      end else if (state_ff == ST_ROUND) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

endmodule

// File: rtl/sha256_message_hasher.sv
// SHA-256 message hasher top level.
// Depends on sha_pkg, sha_front and sha_core.
//
// Usage: message bytes enter on the req_ channel, one per transaction, with
// req_end_of_message on the last. An end transaction without a byte closes
// the message (or gives the empty-message digest when nothing came before).
// The digest leaves on the rsp_ channel as eight 32-bit words, word 0 first,
// rsp_last_word marking word 7.
// The 64th byte of a block starts the 64 rounds of the single shared round
// unit and then the chaining addition, during which the input queue of two
// entries fills and then holds off req_ready. An end transaction adds a
// padding step and the rounds and chaining addition of each final block
// (one or two), then the eight output words.
// A stalled receiver holds the current word; the core waits until it is taken.
// Reset clears the queue, the length and fill counts and loads the standard
// initial hash values; the schedule window needs no clearing.
module sha256_message_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_number,
   output logic        rsp_last_word
);
   import sha_pkg::*;

   item_type in_item, q_item;
   logic     q_valid, q_ready;

   assign in_item = '{data_byte: req_data_byte, byte_present: req_byte_present,
                      end_of_message: req_end_of_message};

   sha_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   sha_core u_core (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .rsp_valid, .rsp_ready, .rsp_digest_word, .rsp_word_number, .rsp_last_word
   );

   a_last_is_seven: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_number == 3'd7)))
      else $error("last word flag does not match word number");

   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=>
         (rsp_valid && rsp_word_number == $past(rsp_word_number) + 3'd1))
      else $error("digest words out of order");

   a_no_take_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !q_ready)
      else $error("core accepted a transaction while emitting");

endmodule
